>>> rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define BPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/core/bpc_pkg.sv
// Types, constants and helpers of the pressure compensation unit.
package bpc_pkg;
  localparam int NUM_CAL = 5;
  localparam int CAL_IDX_W = 3;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;
  localparam int SIDE_W = 64;
  localparam int DIV_STAGES = 32;

  localparam logic [CAL_IDX_W-1:0] CAL_WORD_0 = 3'd0;
  localparam logic [CAL_IDX_W-1:0] CAL_WORD_1 = 3'd1;
  localparam logic [CAL_IDX_W-1:0] CAL_WORD_2 = 3'd2;
  localparam logic [CAL_IDX_W-1:0] CAL_WORD_3 = 3'd3;
  localparam logic [CAL_IDX_W-1:0] CAL_WORD_4 = 3'd4;

  localparam logic [31:0] K_4000 = 32'd4000;
  localparam logic [31:0] K_3038 = 32'd3038;
  localparam logic [31:0] K_NEG_7357 = 32'hFFFF_E343;
  localparam logic [31:0] K_3791 = 32'd3791;
  localparam logic [31:0] K_32768 = 32'd32768;
  localparam logic [31:0] K_50000 = 32'd50000;

  typedef logic [SIDE_W-1:0] side_t;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temp_tenths;
    logic signed [31:0] pressure_pa;
    logic divide_fault;
  } out_item_t;

  typedef struct packed {
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  } coef_t;

  typedef struct packed {
    logic [31:0] x1;
    logic [15:0] up;
  } front_item_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(logic [31:0] x, int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic coef_t decode(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                                   logic [31:0] w3, logic [31:0] w4);
    coef_t c;
    c.ac1 = sx16(w0[31:16]);
    c.ac2 = sx16(w0[15:0]);
    c.ac3 = sx16(w1[31:16]);
    c.ac4 = {16'd0, w1[15:0]};
    c.ac5 = {16'd0, w2[31:16]};
    c.ac6 = {16'd0, w2[15:0]};
    c.b1  = sx16(w3[31:16]);
    c.b2  = sx16(w3[15:0]);
    c.mc  = sx16(w4[31:16]);
    c.md  = sx16(w4[15:0]);
    return c;
  endfunction
endpackage

>>> rtl/core/bpc_if.sv
// Valid/ready channel interfaces for samples and results.
interface bpc_in_if;
  import bpc_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/bpc_front.sv
// Front end: accepts samples and forms the first temperature term.
module bpc_front (
  input  logic clk,
  input  logic rst,
  input  bpc_pkg::coef_t coef,
  bpc_in_if.sink samples,
  input  logic q_full,
  output logic push,
  output bpc_pkg::front_item_t push_data
);
  import bpc_pkg::*;

  logic f_v;
  logic accept;
  logic [31:0] diff;

  assign samples.ready = !f_v || !q_full;
  assign accept = samples.valid && samples.ready;
  assign push = f_v && !q_full;
  assign diff = {16'd0, samples.data.raw_temp} - coef.ac6;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (accept) begin
      f_v <= 1'b1;
    end else if (push) begin
      f_v <= 1'b0;
    end
    if (accept) begin
      push_data.x1 <= asr(32'(diff * coef.ac5), 15);
      push_data.up <= samples.data.raw_pressure;
    end
  end
endmodule

>>> rtl/core/bpc_queue.sv
// Short queue between the front end and the back end.
module bpc_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  bpc_pkg::front_item_t push_data,
  input  logic pop,
  output bpc_pkg::front_item_t pop_data,
  output bpc_pkg::queue_stat_t stat
);
  import bpc_pkg::*;

  front_item_t mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign stat.count = count;
  assign stat.full = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end
endmodule

>>> rtl/core/bpc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module bpc_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [31:0] num,
  input  logic [31:0] den,
  input  bpc_pkg::side_t in_side,
  output logic out_valid,
  output logic [31:0] quot,
  output bpc_pkg::side_t out_side
);
  import bpc_pkg::*;

  logic [31:0] rem [DIV_STAGES+1];
  logic [31:0] nq [DIV_STAGES+1];
  logic [31:0] dd [DIV_STAGES+1];
  logic vld [DIV_STAGES+1];
  side_t sd [DIV_STAGES+1];

  assign rem[0] = '0;
  assign nq[0] = num;
  assign dd[0] = den;
  assign vld[0] = in_valid;
  assign sd[0] = in_side;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [32:0] rs;
    logic [32:0] sub;
    logic ge;
    assign rs = {rem[i], nq[i][31]};
    assign sub = rs - {1'b0, dd[i]};
    assign ge = (rs >= {1'b0, dd[i]});
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1] <= ge ? sub[31:0] : rs[31:0];
        nq[i+1] <= {nq[i][30:0], ge};
        dd[i+1] <= dd[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign quot = nq[DIV_STAGES];
  assign out_side = sd[DIV_STAGES];
endmodule

>>> rtl/core/bpc_back.sv
// Back end: compensation pipeline with two dividers and the result register.
module bpc_back (
  input  logic clk,
  input  logic rst,
  input  bpc_pkg::coef_t coef,
  input  bpc_pkg::queue_stat_t stat,
  input  bpc_pkg::front_item_t pop_data,
  output logic pop,
  bpc_out_if.source results
);
  import bpc_pkg::*;

  logic en;
  logic [31:0] tdiv, num1;

  logic s0_v;
  logic [31:0] s0_ua, s0_ub;
  side_t s0_side;
  logic d1_v;
  logic [31:0] d1_q;
  side_t d1_side;

  logic s1_v, s1_f;
  logic [31:0] s1_temp, s1_b6;
  logic [15:0] s1_up;
  logic [31:0] d1_x1, d1_x2, d1_b5;

  logic s2_v, s2_f;
  logic [31:0] s2_temp, s2_sqr, s2_a2, s2_a3;
  logic [15:0] s2_up;

  logic s3_v, s3_f;
  logic [31:0] s3_temp, s3_m1, s3_m2, s3_a2, s3_a3;
  logic [15:0] s3_up;
  logic [31:0] sq;

  logic s4_v, s4_f;
  logic [31:0] s4_temp, s4_b3, s4_x3p;
  logic [15:0] s4_up;
  logic [31:0] x3, bv;

  logic s5_v, s5_f;
  logic [31:0] s5_temp, s5_b4, s5_b7;

  logic s6_v;
  logic [31:0] s6_num, s6_den;
  side_t s6_side;
  logic d2_v;
  logic [31:0] d2_q;
  side_t d2_side;

  logic s7_v, s7_f;
  logic [31:0] s7_temp, s7_p;

  logic s8_v, s8_f;
  logic [31:0] s8_temp, s8_p, s8_x1, s8_x2;
  logic [31:0] ps;

  logic s9_v, s9_f;
  logic [31:0] s9_temp, s9_p, s9_x1, s9_x2;
  logic [31:0] pfin;

  assign en = !results.valid || results.ready;
  assign pop = en && !stat.empty;
  assign tdiv = pop_data.x1 + coef.md;
  assign num1 = {coef.mc[20:0], 11'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= pop;
    end
    if (en) begin
      s0_ua <= num1[31] ? (32'd0 - num1) : num1;
      s0_ub <= (tdiv == '0) ? 32'd1 : (tdiv[31] ? (32'd0 - tdiv) : tdiv);
      s0_side <= {pop_data.x1, pop_data.up, num1[31] ^ tdiv[31], tdiv == '0, 14'd0};
    end
  end

  bpc_div u_div_temp (
    .clk(clk), .rst(rst), .en(en), .in_valid(s0_v), .num(s0_ua), .den(s0_ub),
    .in_side(s0_side), .out_valid(d1_v), .quot(d1_q), .out_side(d1_side)
  );

  assign d1_x1 = d1_side[63:32];
  assign d1_x2 = d1_side[15] ? (32'd0 - d1_q) : d1_q;
  assign d1_b5 = d1_x1 + d1_x2;
  assign sq = asr(s2_sqr, 12);
  assign x3 = asr(s3_m2, 11) + asr(s3_a2, 11);
  assign bv = {coef.ac1[29:0], 2'd0} + x3 + 32'd2;
  assign ps = asr(s7_p, 8);
  assign pfin = s9_p + asr(asr(s9_x1, 16) + s9_x2 + K_3791, 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else if (en) begin
      s1_v <= d1_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
    end
    if (en) begin
      s1_temp <= asr(d1_b5 + 32'd8, 4);
      s1_b6 <= d1_b5 - K_4000;
      s1_up <= d1_side[31:16];
      s1_f <= d1_side[14];

      s2_sqr <= 32'(s1_b6 * s1_b6);
      s2_a2 <= 32'(coef.ac2 * s1_b6);
      s2_a3 <= 32'(coef.ac3 * s1_b6);
      s2_temp <= s1_temp;
      s2_up <= s1_up;
      s2_f <= s1_f;

      s3_m2 <= 32'(coef.b2 * sq);
      s3_m1 <= 32'(coef.b1 * sq);
      s3_a2 <= s2_a2;
      s3_a3 <= s2_a3;
      s3_temp <= s2_temp;
      s3_up <= s2_up;
      s3_f <= s2_f;

      s4_b3 <= asr(bv + (bv[31] ? 32'd3 : 32'd0), 2);
      s4_x3p <= asr(asr(s3_a3, 13) + asr(s3_m1, 16) + 32'd2, 2);
      s4_temp <= s3_temp;
      s4_up <= s3_up;
      s4_f <= s3_f;

      s5_b4 <= 32'(coef.ac4 * (s4_x3p + K_32768)) >> 15;
      s5_b7 <= 32'(({16'd0, s4_up} - s4_b3) * K_50000);
      s5_temp <= s4_temp;
      s5_f <= s4_f;

      s6_num <= s5_b7[31] ? s5_b7 : {s5_b7[30:0], 1'b0};
      s6_den <= (s5_b4 == '0) ? 32'd1 : s5_b4;
      s6_side <= {s5_temp, !s5_b7[31], s5_f || (s5_b4 == '0), 30'd0};
    end
  end

  bpc_div u_div_press (
    .clk(clk), .rst(rst), .en(en), .in_valid(s6_v), .num(s6_num), .den(s6_den),
    .in_side(s6_side), .out_valid(d2_v), .quot(d2_q), .out_side(d2_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
      s8_v <= 1'b0;
      s9_v <= 1'b0;
      results.valid <= 1'b0;
    end else if (en) begin
      s7_v <= d2_v;
      s8_v <= s7_v;
      s9_v <= s8_v;
      results.valid <= s9_v;
    end
    if (en) begin
      s7_p <= d2_side[31] ? d2_q : {d2_q[30:0], 1'b0};
      s7_temp <= d2_side[63:32];
      s7_f <= d2_side[30];

      s8_x1 <= 32'(ps * ps);
      s8_x2 <= 32'(K_NEG_7357 * s7_p);
      s8_p <= s7_p;
      s8_temp <= s7_temp;
      s8_f <= s7_f;

      s9_x1 <= 32'(s8_x1 * K_3038);
      s9_x2 <= asr(s8_x2, 16);
      s9_p <= s8_p;
      s9_temp <= s8_temp;
      s9_f <= s8_f;

      results.data.temp_tenths <= s9_f ? '0 : $signed(s9_temp);
      results.data.pressure_pa <= s9_f ? '0 : $signed(pfin);
      results.data.divide_fault <= s9_f;
    end
  end
endmodule

>>> rtl/core/barometric_pressure_compensation_unit.sv
// One sample per cycle unless results stall; two 32-stage pipelined dividers set the depth.
// A stalled result register freezes the back pipeline; a 4-entry queue absorbs the front.
// Reset (synchronous, active high) clears all valid flags, the queue and the calibration words.
// The user must write calibration words only while no sample is in flight (not enforced).
`include "assert_macros.svh"
module barometric_pressure_compensation_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [bpc_pkg::CAL_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  bpc_in_if.sink samples,
  bpc_out_if.source results
);
  import bpc_pkg::*;

  logic [31:0] cal [NUM_CAL];
  coef_t coef;
  logic push, pop;
  front_item_t push_data, pop_data;
  queue_stat_t stat;
  logic out_fault, out_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CAL; i++) begin
        cal[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CAL_WORD_0: cal[0] <= cfg_data;
        CAL_WORD_1: cal[1] <= cfg_data;
        CAL_WORD_2: cal[2] <= cfg_data;
        CAL_WORD_3: cal[3] <= cfg_data;
        CAL_WORD_4: cal[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coef = decode(cal[0], cal[1], cal[2], cal[3], cal[4]);

  bpc_front u_front (
    .clk(clk), .rst(rst), .coef(coef), .samples(samples),
    .q_full(stat.full), .push(push), .push_data(push_data)
  );

  bpc_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .stat(stat)
  );

  bpc_back u_back (
    .clk(clk), .rst(rst), .coef(coef), .stat(stat),
    .pop_data(pop_data), .pop(pop), .results(results)
  );

  assign out_fault = results.valid && results.data.divide_fault;
  assign out_zero = (results.data.temp_tenths == 0) && (results.data.pressure_pa == 0);

  `BPC_ASSERT_IMPL(a_fault_zero, out_fault, out_zero)
  `BPC_ASSERT_IMPL(a_queue_bound, 1'b1, stat.count <= QCNT_W'(QDEPTH))
  `BPC_ASSERT_IMPL(a_ready_cause, !samples.ready, stat.full)
  `BPC_ASSERT_NEXT(a_no_push_full, stat.full && !pop, stat.count == QCNT_W'(QDEPTH))
endmodule
